[hdl/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// Holds the command codes, the sequencer state record and the phase-count function.
// No dependencies.
package i2cm_pkg;

	// Command codes carried in the kind field; IDLE doubles as the tick code
	typedef enum logic [2:0] {
		CMD_IDLE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_STOP    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_READ    = 3'd4,
		CMD_WAITACK = 3'd5
	} cmd_e_t;

	// Acknowledge modes after a read
	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_SEND = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;
	localparam logic [1:0] ACK_RSVD = 2'd3;

	// Write phase positions inside one bit slot
	localparam logic [1:0] SUB_DATA = 2'd0;
	localparam logic [1:0] SUB_HIGH = 2'd1;
	localparam logic [1:0] SUB_LOW  = 2'd2;

	localparam logic [2:0] LAST_BIT = 3'd7;
	localparam logic [7:0] MSB_MASK = 8'h80;

	// Sequencer state; sub and bit_idx track phase mod 3 and phase / 3 for writes
	typedef struct packed {
		cmd_e_t     cmd;
		logic [4:0] phase;
		logic [1:0] sub;
		logic [2:0] bit_idx;
		logic [7:0] shift;
		logic [7:0] rx;
		logic [1:0] ack_mode;
		logic       scl;
		logic       sda;
		logic       nack;
	} seq_state_t;

	localparam seq_state_t SEQ_RESET = '{
		cmd: CMD_IDLE, phase: 5'd0, sub: SUB_DATA, bit_idx: 3'd0,
		shift: 8'd0, rx: 8'd0, ack_mode: ACK_NONE,
		scl: 1'b1, sda: 1'b1, nack: 1'b0
	};

	// One result word
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack;
		logic       rejected;
	} seq_res_t;

	// Number of line phases a command takes
	function automatic logic [4:0] total_phases(cmd_e_t cmd, logic [1:0] ack_mode);
		logic [4:0] n;
		n = 5'd0;
		unique case (cmd)
			CMD_START:   n = 5'd4;
			CMD_STOP:    n = 5'd2;
			CMD_WRITE:   n = 5'd24;
			CMD_READ: begin
				if (ack_mode == ACK_SEND) n = 5'd20;
				else if (ack_mode == ACK_NACK) n = 5'd19;
				else n = 5'd16;
			end
			CMD_WAITACK: n = 5'd3;
			default:     n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

[hdl/i2cm_cmd_if.sv]
// Input channel of the I2C master bit sequencer: valid/ready plus command word.
// Depends on nothing.
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic [1:0] ack_mode;
	logic       sda_in;

	modport source (output valid, kind, data_byte, ack_mode, sda_in, input ready);
	modport sink (input valid, kind, data_byte, ack_mode, sda_in, output ready);
endinterface

[hdl/i2cm_res_if.sv]
// Output channel of the I2C master bit sequencer: valid/ready plus result word.
// Depends on nothing.
interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       nack;
	logic       rejected;

	modport source (output valid, scl, sda, busy_res, done_res, read_data, nack, rejected,
		input ready);
	modport sink (input valid, scl, sda, busy_res, done_res, read_data, nack, rejected,
		output ready);
endinterface

[hdl/i2cm_step.sv]
// Next-state and result logic for one word of the I2C master bit sequencer.
// Depends on i2cm_pkg.
module i2cm_step
	import i2cm_pkg::*;
(
	input  seq_state_t st,
	input  logic [2:0] kind,
	input  logic [7:0] data_byte,
	input  logic [1:0] ack_mode,
	input  logic       sda_in,
	output seq_state_t st_next,
	output seq_res_t   res
);

	logic       is_cmd;
	logic       done;
	logic       rej;
	logic [4:0] phase_inc;

	assign is_cmd = (kind >= 3'(CMD_START)) && (kind <= 3'(CMD_WAITACK));
	assign phase_inc = st.phase + 5'd1;

	always_comb begin
		st_next = st;
		done = 1'b0;
		rej = 1'b0;
		if (st.cmd != CMD_IDLE) begin
			if (is_cmd) begin
				rej = 1'b1;
			end else begin
				// run one line phase of the active command
				unique case (st.cmd)
					CMD_START: begin
						case (st.phase[1:0])
							2'd0: st_next.sda = 1'b1;
							2'd1: st_next.scl = 1'b1;
							2'd2: st_next.sda = 1'b0;
							default: st_next.scl = 1'b0;
						endcase
					end
					CMD_STOP: begin
						if (st.phase == 5'd0) begin
							st_next.sda = 1'b0;
							st_next.scl = 1'b1;
						end else begin
							st_next.sda = 1'b1;
						end
					end
					CMD_WRITE: begin
						case (st.sub)
							SUB_DATA: begin
								st_next.sda = |(st.shift & MSB_MASK);
								st_next.sub = SUB_HIGH;
							end
							SUB_HIGH: begin
								st_next.scl = 1'b1;
								st_next.sub = SUB_LOW;
							end
							default: begin
								st_next.scl = 1'b0;
								st_next.shift = {st.shift[6:0], 1'b0};
								if (st.bit_idx == LAST_BIT) st_next.sda = 1'b1;
								st_next.sub = SUB_DATA;
								st_next.bit_idx = st.bit_idx + 3'd1;
							end
						endcase
					end
					CMD_READ: begin
						if (!st.phase[4]) begin
							// data bits: sample on the high phase
							if (!st.phase[0]) begin
								st_next.scl = 1'b1;
								st_next.shift = {st.shift[6:0], sda_in};
							end else begin
								st_next.scl = 1'b0;
							end
						end else begin
							// acknowledge slot
							case (st.phase[1:0])
								2'd0: st_next.sda = (st.ack_mode != ACK_SEND);
								2'd1: st_next.scl = 1'b1;
								2'd2: st_next.scl = 1'b0;
								default: st_next.sda = 1'b1;
							endcase
						end
					end
					CMD_WAITACK: begin
						if (st.phase == 5'd0) begin
							st_next.sda = 1'b1;
						end else if (st.phase == 5'd1) begin
							st_next.scl = 1'b1;
							st_next.nack = sda_in;
						end else begin
							st_next.scl = 1'b0;
						end
					end
					default: ;
				endcase
				st_next.phase = phase_inc;
				// completion check
				if (phase_inc >= total_phases(st.cmd, st.ack_mode)) begin
					if (st.cmd == CMD_READ) st_next.rx = st_next.shift;
					done = 1'b1;
					st_next.cmd = CMD_IDLE;
					st_next.phase = 5'd0;
				end
			end
		end else if (is_cmd) begin
			// load a new command
			st_next.cmd = cmd_e_t'(kind);
			st_next.phase = 5'd0;
			st_next.sub = SUB_DATA;
			st_next.bit_idx = 3'd0;
			st_next.shift = (kind == 3'(CMD_WRITE)) ? data_byte : 8'd0;
			st_next.ack_mode = ((kind == 3'(CMD_READ)) && (ack_mode != ACK_RSVD)) ?
				ack_mode : ACK_NONE;
		end
	end

	// result word reflects the state after the step
	always_comb begin
		res.scl = st_next.scl;
		res.sda = st_next.sda;
		res.busy_res = (st_next.cmd != CMD_IDLE);
		res.done_res = done;
		res.read_data = st_next.rx;
		res.nack = st_next.nack;
		res.rejected = rej;
	end

endmodule

[hdl/i2c_master_bit_sequencer_core.sv]
// Top level of the I2C master bit sequencer: input register, step logic, result register.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2cm_step.
//
// I2C master line sequencer. A command word (start, stop, write byte, read byte with
// optional ACK/NACK, wait acknowledge) is loaded while idle; each following tick word
// moves the bus one phase and carries the sampled SDA level. Every accepted word gives
// exactly one result word with the SCL/SDA levels (SDA 1 = released), busy, done on the
// last tick of a command, the last read byte, the last acknowledge result, and a
// rejected flag for a command that arrived while busy. Throughput is one word per clock
// while the output is not stalled: the sequencer state updates in one pass of the step
// logic. The input register takes the word at acceptance, the result register takes its
// result when it is free or being emptied, and the result word is offered from there.
// A stalled output holds the result register and backs up into the input register.
module i2c_master_bit_sequencer_core
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res
);

	logic       v_s1;
	logic [2:0] kind_s1;
	logic [7:0] data_byte_s1;
	logic [1:0] ack_mode_s1;
	logic       sda_in_s1;

	logic       res_v_q;
	seq_res_t   res_q;
	seq_state_t st_q;

	seq_state_t st_next;
	seq_res_t   res_next;
	logic       adv_s1;

	// stage 1 moves on when the result register is free or being emptied
	assign adv_s1 = v_s1 && (!res_v_q || res.ready);
	assign cmd.ready = !v_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			kind_s1 <= cmd.kind;
			data_byte_s1 <= cmd.data_byte;
			ack_mode_s1 <= cmd.ack_mode;
			sda_in_s1 <= cmd.sda_in;
		end
	end

	i2cm_step u_step (
		.st        (st_q),
		.kind      (kind_s1),
		.data_byte (data_byte_s1),
		.ack_mode  (ack_mode_s1),
		.sda_in    (sda_in_s1),
		.st_next   (st_next),
		.res       (res_next)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SEQ_RESET;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv_s1) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_q <= res_next;
	end

	assign res.valid = res_v_q;
	assign res.scl = res_q.scl;
	assign res.sda = res_q.sda;
	assign res.busy_res = res_q.busy_res;
	assign res.done_res = res_q.done_res;
	assign res.read_data = res_q.read_data;
	assign res.nack = res_q.nack;
	assign res.rejected = res_q.rejected;

endmodule

[tb/i2c_master_bit_sequencer_core_tb.sv]
// Self-checking testbench for i2c_master_bit_sequencer_core: random and directed command words,
// a cycle-accurate line predictor, and random stalls on both valid/ready channels.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and the core itself.
module i2c_master_bit_sequencer_core_tb;
	import i2cm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Unused kind codes, which the core treats as ticks
	localparam logic [2:0] KIND_UNUSED_A = 3'd6;
	localparam logic [2:0] KIND_UNUSED_B = 3'd7;

	// SDA sampling pattern for generated sequences
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;

	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 100;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic [1:0] ack_mode;
		logic       sda_in;
	} cmd_word_t;

	// Predicted line state
	typedef struct {
		cmd_e_t     cmd;
		logic [4:0] phase;
		logic [7:0] shreg;
		logic [7:0] rx_byte;
		logic [1:0] ack_sel;
		logic       scl;
		logic       sda;
		logic       nack;
	} line_state_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();

	i2c_master_bit_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always #10 clk = ~clk;

	cmd_word_t   pending_words[$];
	seq_res_t    expected_levels[$];
	line_state_t line_st = '{cmd: CMD_IDLE, phase: 5'd0, shreg: 8'd0, rx_byte: 8'd0,
		ack_sel: ACK_NONE, scl: 1'b1, sda: 1'b1, nack: 1'b0};

	int unsigned src_idle_pct  = 0;
	int unsigned rcv_stall_pct = 0;
	int          hold_asks     = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;
	int          fail_count    = 0;
	int          words_queued  = 0;
	int          quiet_cycles  = 0;
	cmd_word_t   offered_word;

	// Line phases taken by one command
	function automatic logic [4:0] bus_phases(cmd_e_t c, logic [1:0] m);
		case (c)
			CMD_START:   return 5'd4;
			CMD_STOP:    return 5'd2;
			CMD_WRITE:   return 5'd24;
			CMD_READ:    return (m == ACK_SEND) ? 5'd20 : (m == ACK_NACK) ? 5'd19 : 5'd16;
			CMD_WAITACK: return 5'd3;
			default:     return 5'd0;
		endcase
	endfunction

	// Advance the predicted line by one accepted word and give the result word
	function automatic seq_res_t bus_step(cmd_word_t w);
		seq_res_t   r;
		logic       is_cmd;
		logic       done;
		logic       refused;
		logic [4:0] p;
		logic [4:0] k;
		is_cmd  = (w.kind >= CMD_START) && (w.kind <= CMD_WAITACK);
		done    = 1'b0;
		refused = 1'b0;
		if (line_st.cmd != CMD_IDLE) begin
			if (is_cmd) begin
				refused = 1'b1;
			end else begin
				p = line_st.phase;
				case (line_st.cmd)
					CMD_START: begin
						if (p == 5'd0) line_st.sda = 1'b1;
						else if (p == 5'd1) line_st.scl = 1'b1;
						else if (p == 5'd2) line_st.sda = 1'b0;
						else line_st.scl = 1'b0;
					end
					CMD_STOP: begin
						if (p == 5'd0) begin
							line_st.sda = 1'b0;
							line_st.scl = 1'b1;
						end else begin
							line_st.sda = 1'b1;
						end
					end
					CMD_WRITE: begin
						if (p % 3 == 0) begin
							line_st.sda = line_st.shreg[7];
						end else if (p % 3 == 1) begin
							line_st.scl = 1'b1;
						end else begin
							line_st.scl   = 1'b0;
							line_st.shreg = {line_st.shreg[6:0], 1'b0};
							// SDA released after the last bit
							if (p / 3 == 7) line_st.sda = 1'b1;
						end
					end
					CMD_READ: begin
						if (p < 5'd16) begin
							if (!p[0]) begin
								line_st.scl   = 1'b1;
								line_st.shreg = {line_st.shreg[6:0], w.sda_in};
							end else begin
								line_st.scl = 1'b0;
							end
						end else begin
							k = p - 5'd16;
							if (k == 5'd0)
								line_st.sda = (line_st.ack_sel == ACK_SEND) ? 1'b0 : 1'b1;
							else if (k == 5'd1) line_st.scl = 1'b1;
							else if (k == 5'd2) line_st.scl = 1'b0;
							else line_st.sda = 1'b1;
						end
					end
					CMD_WAITACK: begin
						if (p == 5'd0) begin
							line_st.sda = 1'b1;
						end else if (p == 5'd1) begin
							line_st.scl  = 1'b1;
							line_st.nack = w.sda_in;
						end else begin
							line_st.scl = 1'b0;
						end
					end
					default: ;
				endcase
				line_st.phase = p + 5'd1;
				if (line_st.phase >= bus_phases(line_st.cmd, line_st.ack_sel)) begin
					if (line_st.cmd == CMD_READ) line_st.rx_byte = line_st.shreg;
					done          = 1'b1;
					line_st.cmd   = CMD_IDLE;
					line_st.phase = 5'd0;
				end
			end
		end else if (is_cmd) begin
			line_st.cmd     = cmd_e_t'(w.kind);
			line_st.phase   = 5'd0;
			line_st.shreg   = (w.kind == CMD_WRITE) ? w.data_byte : 8'd0;
			line_st.ack_sel = (w.kind == CMD_READ && w.ack_mode != ACK_RSVD) ?
				w.ack_mode : ACK_NONE;
		end
		r.scl       = line_st.scl;
		r.sda       = line_st.sda;
		r.busy_res  = (line_st.cmd != CMD_IDLE);
		r.done_res  = done;
		r.read_data = line_st.rx_byte;
		r.nack      = line_st.nack;
		r.rejected  = refused;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Driver: offers queued words, predicts each accepted word
	always @(posedge clk) begin : drive
		logic      nxt_valid;
		cmd_word_t nxt_word;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) expected_levels.push_back(bus_step(offered_word));
			nxt_valid = cmd_ch.valid && !cmd_ch.ready;
			nxt_word  = offered_word;
			if (!nxt_valid && pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt_word  = pending_words.pop_front();
				nxt_valid = 1'b1;
			end
			offered_word     = nxt_word;
			cmd_ch.valid     <= nxt_valid;
			cmd_ch.kind      <= nxt_word.kind;
			cmd_ch.data_byte <= nxt_word.data_byte;
			cmd_ch.ack_mode  <= nxt_word.ack_mode;
			cmd_ch.sda_in    <= nxt_word.sda_in;
		end
	end

	// Monitor: checks each result word and drives ready
	always @(posedge clk) begin : watch
		seq_res_t want;
		logic     rdy;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_levels.size() == 0) begin
					$error("result word with no expectation pending");
					fail_count++;
				end else begin
					want = expected_levels.pop_front();
					compare_field("scl", want.scl, res_ch.scl);
					compare_field("sda", want.sda, res_ch.sda);
					compare_field("busy_res", want.busy_res, res_ch.busy_res);
					compare_field("done_res", want.done_res, res_ch.done_res);
					compare_field("read_data", want.read_data, res_ch.read_data);
					compare_field("nack", want.nack, res_ch.nack);
					compare_field("rejected", want.rejected, res_ch.rejected);
				end
			end
			// long hold-off to back the core up into its input
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				rdy = ($urandom_range(99) >= rcv_stall_pct);
			end
			res_ch.ready <= rdy;
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_word(logic [2:0] kind, logic [7:0] data, logic [1:0] mode, logic sda);
		pending_words.push_back('{kind: kind, data_byte: data, ack_mode: mode, sda_in: sda});
	endtask

	// Command word then its ticks; noise_pct adds refused commands between ticks
	task automatic queue_sequence(cmd_e_t c, logic [7:0] data, logic [1:0] mode, int sda_pick,
			int noise_pct, int max_ticks);
		int         n;
		int         pick;
		logic [2:0] tk;
		logic       s;
		push_word(c, data, mode, 1'($urandom));
		n = bus_phases(c, (mode == ACK_RSVD) ? ACK_NONE : mode);
		if (max_ticks < n) n = max_ticks;
		words_queued += n + 1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < noise_pct)
				push_word(3'($urandom_range(CMD_WAITACK, CMD_START)), 8'($urandom), 2'($urandom),
					1'($urandom));
			pick = $urandom_range(9);
			tk   = (pick == 0) ? KIND_UNUSED_A : (pick == 1) ? KIND_UNUSED_B : CMD_IDLE;
			s    = (sda_pick == SDA_RAND) ? 1'($urandom) : (sda_pick == SDA_HIGH);
			push_word(tk, 8'($urandom), 2'($urandom), s);
		end
	endtask

	// Mostly well-formed random sequences, some cut short, some loose noise
	task automatic queue_random(int target);
		int r;
		int start_count;
		start_count = words_queued;
		while (words_queued - start_count < target) begin
			r = $urandom_range(99);
			if (r < 80) begin
				queue_sequence(cmd_e_t'($urandom_range(CMD_WAITACK, CMD_START)), 8'($urandom),
					2'($urandom), SDA_RAND, 5, 32);
			end else if (r < 90) begin
				queue_sequence(cmd_e_t'($urandom_range(CMD_WAITACK, CMD_START)), 8'($urandom),
					2'($urandom), SDA_RAND, 20, $urandom_range(8));
			end else begin
				repeat ($urandom_range(3, 1))
					push_word(3'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
			end
		end
	endtask

	// Wait until the sender is done and every result has come back
	task automatic drain();
		while (pending_words.size() != 0 || cmd_ch.valid || expected_levels.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.kind      = CMD_IDLE;
		cmd_ch.data_byte = 8'd0;
		cmd_ch.ack_mode  = ACK_NONE;
		cmd_ch.sda_in    = 1'b0;
		res_ch.ready     = 1'b0;
		offered_word     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle ticks, each command, extreme bytes, every ack mode, refusals
		push_word(CMD_IDLE, 8'hFF, ACK_RSVD, 1'b1);
		push_word(KIND_UNUSED_A, 8'h00, ACK_NONE, 1'b0);
		push_word(KIND_UNUSED_B, 8'hFF, ACK_NACK, 1'b1);
		queue_sequence(CMD_START, 8'h00, ACK_NONE, SDA_LOW, 0, 32);
		queue_sequence(CMD_WRITE, 8'hFF, ACK_NONE, SDA_HIGH, 0, 32);
		queue_sequence(CMD_WAITACK, 8'h00, ACK_NONE, SDA_HIGH, 0, 32);
		queue_sequence(CMD_WRITE, 8'h00, ACK_SEND, SDA_LOW, 100, 32);
		queue_sequence(CMD_WAITACK, 8'hFF, ACK_NONE, SDA_LOW, 0, 32);
		queue_sequence(CMD_READ, 8'h00, ACK_NONE, SDA_HIGH, 0, 32);
		queue_sequence(CMD_READ, 8'hFF, ACK_SEND, SDA_LOW, 0, 32);
		queue_sequence(CMD_READ, 8'h5A, ACK_NACK, SDA_RAND, 0, 32);
		queue_sequence(CMD_READ, 8'hA5, ACK_RSVD, SDA_RAND, 0, 32);
		queue_sequence(CMD_STOP, 8'h00, ACK_NONE, SDA_RAND, 100, 32);
		drain();

		// Idling phases: none, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 69) : 0;
			rcv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 69) : 0;
			queue_random(PHASE_WORDS);
			drain();
		end

		// Receiver holds off while the sender keeps offering
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_asks++;
		queue_random(60);
		drain();

		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
